// ----- rtl/core/ffdl_pkg.sv -----
// ----------------------------------------------------------------------------
// ffdl_pkg
// Shared constants, types and helpers for the fractional feedback delay line.
// ----------------------------------------------------------------------------
package ffdl_pkg;

    // line geometry and sample format
    localparam int LINE_DEPTH  = 4096;
    localparam int SMP_W       = 16;
    localparam int ADDR_BITS   = $clog2(LINE_DEPTH);

    // register field widths
    localparam int MODE_W      = 2;
    localparam int DELAY_W     = 12;
    localparam int FRACT_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 15;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_INT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRACT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL     = 3'd5;

    // operating modes, unused code behaves as feedback delay
    localparam logic [MODE_W-1:0] MODE_FEEDBACK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLPASS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ECHO     = 2'd2;

    // shared multiply-add widths
    localparam int MUL_A_W = SMP_W + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;

    // address arithmetic width, holds twice the depth and any delay value
    localparam int CALC_W  = ((ADDR_BITS > DELAY_W) ? ADDR_BITS : DELAY_W) + 2;

    localparam logic [MUL_B_W-1:0] GAIN_ONE = MUL_B_W'(32768);

    localparam logic signed [ACC_W-1:0] RND_GAIN  = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] RND_FRACT = ACC_W'(32768);

    localparam logic signed [ACC_W-1:0] SMP_MAX =
        {{(ACC_W-SMP_W+1){1'b0}}, {(SMP_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN =
        {{(ACC_W-SMP_W+1){1'b1}}, {(SMP_W-1){1'b0}}};

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTERP,
        ST_DECAY,
        ST_ALLPASS,
        ST_FEED,
        ST_DRY,
        ST_WET
    } state_t;

    // clip a wide value to the sample range
    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        begin
            if (v > SMP_MAX)
                c = SMP_MAX;
            else if (v < SMP_MIN)
                c = SMP_MIN;
            else
                c = v;
            return c[SMP_W-1:0];
        end
    endfunction

    // limit a Q1.15 gain to one
    function automatic logic [MUL_B_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        logic [MUL_B_W-1:0] w;
        begin
            w = {1'b0, g};
            return (w > GAIN_ONE) ? GAIN_ONE : w;
        end
    endfunction

endpackage

// ----- rtl/core/ffdl_mac.sv -----
// ----------------------------------------------------------------------------
// ffdl_mac
// Shared signed multiply-add used by every step of the sequencer.
// ----------------------------------------------------------------------------
module ffdl_mac (
    input  logic signed [ffdl_pkg::MUL_A_W-1:0] a,
    input  logic signed [ffdl_pkg::MUL_B_W-1:0] b,
    input  logic signed [ffdl_pkg::ACC_W-1:0]   c,
    output logic signed [ffdl_pkg::ACC_W-1:0]   y
);
    import ffdl_pkg::*;

    logic signed [PROD_W-1:0] prod;

    // product then sign-extended add
    assign prod = a * b;
    assign y    = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} + c;

endmodule

// ----- rtl/core/fractional_feedback_delay_line_core.sv -----
// ----------------------------------------------------------------------------
// fractional_feedback_delay_line_core
// Circular delay line with linear fractional read, feedback, allpass and echo.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_ready with sample_in; results leave on
//   out_valid/out_ready with sample_out, one result per input sample.
//   Registers are written over cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high and writes are meant for idle time.
//   An accepted sample reads both neighbours from the two-read-port delay
//   memory in its transfer cycle, then one shared multiply-add unit runs the
//   steps: allpass mode runs interpolation, decay and allpass, then loads
//   the result; feedback and echo modes need two more multiply steps
//   (feedback term and the two mix products), running interpolation, decay,
//   feed, dry and wet before the result is loaded.
//   in_ready is high only while the sequencer is idle.
//   The result sits in an output register; while the receiver stalls the
//   final step waits, and no new sample is taken until then.
//   Reset clears the registers to their defaults and the write pointer to
//   zero; the memory is not swept, a full flag and the write pointer mark
//   unwritten entries, read as zero, so samples are taken right after reset.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_line_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [ffdl_pkg::SMP_W-1:0]      sample_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [ffdl_pkg::SMP_W-1:0]      sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ffdl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ffdl_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import ffdl_pkg::*;

    // configuration registers
    logic [MODE_W-1:0]   mode_reg;
    logic [DELAY_W-1:0]  delay_int_reg;
    logic [FRACT_W-1:0]  delay_fract_reg;
    logic [GAIN_W-1:0]   decay_gain_reg;
    logic [GAIN_W-1:0]   feedback_gain_reg;
    logic [GAIN_W-1:0]   wet_level_reg;

    // sequencer and pointer
    state_t              state_reg, state_next;
    logic [ADDR_BITS-1:0] wp_reg, wp_next;
    logic                full_reg;

    // datapath registers
    logic signed [SMP_W-1:0] x_reg;
    logic signed [SMP_W-1:0] rd_new_reg, rd_old_reg;
    logic                    new_ok_reg, old_ok_reg;
    logic signed [SMP_W-1:0] i_reg, v_reg, b_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] sample_out_reg;

    // delay memory
    logic signed [SMP_W-1:0] mem [LINE_DEPTH];

    // control
    logic                    in_fire, out_free, mem_we, res_load;
    logic signed [SMP_W-1:0] wr_data, res_value;

    // clamped gains
    logic [MUL_B_W-1:0] dg, fg, wg;

    // address arithmetic
    logic [CALC_W-1:0]    d_sat, base_sum, old_sum;
    logic [ADDR_BITS-1:0] addr_new, addr_old;
    logic                 d_zero;

    // interpolation inputs
    logic signed [SMP_W-1:0] x0, x1;

    // shared unit ports
    logic signed [MUL_A_W-1:0] mac_a;
    logic signed [MUL_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   mac_c, mac_y;
    logic signed [ACC_W-1:0]   y_g, y_f;
    logic signed [SMP_W-1:0]   v_calc, mix;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;

    assign dg = clamp_gain(decay_gain_reg);
    assign fg = clamp_gain(feedback_gain_reg);
    assign wg = clamp_gain(wet_level_reg);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_FEEDBACK;
            delay_int_reg     <= '0;
            delay_fract_reg   <= '0;
            decay_gain_reg    <= GAIN_W'(32768);
            feedback_gain_reg <= '0;
            wet_level_reg     <= GAIN_W'(32768);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:          mode_reg          <= cfg_data[MODE_W-1:0];
                REG_DELAY_INT:     delay_int_reg     <= cfg_data[DELAY_W-1:0];
                REG_DELAY_FRACT:   delay_fract_reg   <= cfg_data[FRACT_W-1:0];
                REG_DECAY_GAIN:    decay_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_WET_LEVEL:     wet_level_reg     <= cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // read addresses, delay limited to depth minus two
    always_comb
    begin
        if (CALC_W'(delay_int_reg) > CALC_W'(LINE_DEPTH - 2))
            d_sat = CALC_W'(LINE_DEPTH - 2);
        else
            d_sat = CALC_W'(delay_int_reg);
        d_zero   = (d_sat == '0);
        base_sum = CALC_W'(wp_reg) + CALC_W'(LINE_DEPTH) - d_sat;
        old_sum  = base_sum - CALC_W'(1);
        if (base_sum >= CALC_W'(LINE_DEPTH))
            addr_new = ADDR_BITS'(base_sum - CALC_W'(LINE_DEPTH));
        else
            addr_new = ADDR_BITS'(base_sum);
        if (old_sum >= CALC_W'(LINE_DEPTH))
            addr_old = ADDR_BITS'(old_sum - CALC_W'(LINE_DEPTH));
        else
            addr_old = ADDR_BITS'(old_sum);
    end

    // memory: reads on input transfer, one write per sample
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= wr_data;
        if (in_fire)
        begin
            rd_new_reg <= mem[addr_new];
            rd_old_reg <= mem[addr_old];
        end
    end

    // capture input and fill status of the read entries
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg      <= sample_in;
            new_ok_reg <= full_reg || (addr_new < wp_reg);
            old_ok_reg <= full_reg || (addr_old < wp_reg);
        end
    end

    // neighbours, unwritten entries read as zero, zero delay uses the input
    assign x0 = d_zero ? x_reg : (new_ok_reg ? rd_new_reg : '0);
    assign x1 = old_ok_reg ? rd_old_reg : '0;

    // operand select for the shared unit
    always_comb
    begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
        case (state_reg)
            ST_INTERP:
            begin
                mac_a = MUL_A_W'(x1) - MUL_A_W'(x0);
                mac_b = {1'b0, delay_fract_reg};
                mac_c = RND_FRACT;
            end
            ST_DECAY:
            begin
                mac_a = MUL_A_W'(i_reg);
                mac_b = dg;
                mac_c = RND_GAIN;
            end
            ST_ALLPASS:
            begin
                mac_a = MUL_A_W'(b_reg);
                mac_b = dg;
                mac_c = RND_GAIN;
            end
            ST_FEED:
            begin
                mac_a = MUL_A_W'(v_reg);
                mac_b = fg;
                mac_c = RND_GAIN;
            end
            ST_DRY:
            begin
                mac_a = MUL_A_W'(x_reg);
                mac_b = GAIN_ONE - wg;
                mac_c = RND_GAIN;
            end
            ST_WET:
            begin
                mac_a = MUL_A_W'(v_reg);
                mac_b = wg;
                mac_c = acc_reg;
            end
            default: ;
        endcase
    end

    ffdl_mac u_mac (
        .a (mac_a),
        .b (mac_b),
        .c (mac_c),
        .y (mac_y)
    );

    // post-shift results
    assign y_g    = mac_y >>> GAIN_FRAC;
    assign y_f    = mac_y >>> FRACT_W;
    assign v_calc = sat_smp(y_g);
    assign mix    = sat_smp(y_g);

    // write value and result value
    always_comb
    begin
        if (d_zero)
            wr_data = x_reg;
        else if (state_reg == ST_ALLPASS)
            wr_data = b_reg;
        else
            wr_data = sat_smp(ACC_W'(x_reg) + y_g);

        if (state_reg == ST_ALLPASS)
            res_value = sat_smp(ACC_W'(i_reg) + y_g);
        else if (mode_reg == MODE_ECHO)
            res_value = sat_smp(ACC_W'(x_reg) + ACC_W'(mix));
        else
            res_value = mix;
    end

    // step results
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_INTERP:
                i_reg <= sat_smp(ACC_W'(x0) + y_f);
            ST_DECAY:
            begin
                v_reg <= v_calc;
                b_reg <= sat_smp(ACC_W'(x_reg) - ACC_W'(v_calc));
            end
            ST_DRY:
                acc_reg <= mac_y;
            default: ;
        endcase
    end

    // sequencer next state and strobes
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        res_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_INTERP;
            end
            ST_INTERP:
                state_next = ST_DECAY;
            ST_DECAY:
                state_next = (mode_reg == MODE_ALLPASS) ? ST_ALLPASS : ST_FEED;
            ST_ALLPASS:
            begin
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FEED:
            begin
                mem_we     = 1'b1;
                state_next = ST_DRY;
            end
            ST_DRY:
                state_next = ST_WET;
            ST_WET:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // write pointer wraps at the line depth
    assign wp_next = (wp_reg == ADDR_BITS'(LINE_DEPTH - 1)) ? '0 : wp_reg + ADDR_BITS'(1);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                wp_reg <= wp_next;
                if (wp_reg == ADDR_BITS'(LINE_DEPTH - 1))
                    full_reg <= 1'b1;
            end
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (res_load)
            sample_out_reg <= res_value;
    end

endmodule

// ----- rtl/core/ffdl_checker.sv -----
// ----------------------------------------------------------------------------
// ffdl_checker
// Port-level checks for the delay line core, attached by bind.
// ----------------------------------------------------------------------------
module ffdl_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ffdl_pkg::SMP_W-1:0] sample_out,
    input logic                              cfg_valid,
    input logic                              cfg_ready
);
    import ffdl_pkg::*;

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("result changed while stalled");

    // one sample at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input taken while sequencer busy");

    // a result never appears the cycle after its input transfer
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_xfer))
        else $error("result too early");

    // configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind fractional_feedback_delay_line_core ffdl_checker u_ffdl_checker (.*);
